>>> src/smt_dec_pkg.sv
// ============================================================================
// StackMapTable decoder package
// Shared word types, record kinds and the verification type tag decode.
// ============================================================================
`default_nettype none

package smt_dec_pkg;

    localparam logic [2:0] KIND_SAME   = 3'd0;
    localparam logic [2:0] KIND_APPEND = 3'd1;
    localparam logic [2:0] KIND_LOCAL  = 3'd2;
    localparam logic [2:0] KIND_EMPTY  = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic ERR_FRAME_TYPE = 1'b0;
    localparam logic ERR_TYPE_TAG   = 1'b1;

    localparam logic [7:0] SAME_MAX     = 8'd63;
    localparam logic [7:0] APPEND_MIN   = 8'd252;
    localparam logic [7:0] APPEND_MAX   = 8'd254;
    localparam logic [7:0] APPEND_BASE  = 8'd251;
    localparam logic [7:0] TAG_MAX      = 8'd8;
    localparam logic [7:0] TAG_CLASS    = 8'd7;
    localparam logic [7:0] TAG_UNINIT   = 8'd8;
    localparam logic [3:0] CODE_UNINIT_OFFSET = 4'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] bci;
        logic [1:0]  local_count;
        logic [3:0]  type_code;
        logic [15:0] type_offset;
        logic        error_code;
        logic        table_end;
    } t_out_word;

    function automatic logic [3:0] tag_to_code(input logic [3:0] tag);
        logic [3:0] code;
        case (tag)
            4'd3:    code = 4'd8;
            4'd4:    code = 4'd7;
            4'd5:    code = 4'd3;
            4'd6:    code = 4'd4;
            4'd7:    code = 4'd5;
            4'd8:    code = 4'd6;
            default: code = tag;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> src/stack_map_table_decoder.sv
// Registers: a word is registered in r_in on acceptance and its record, if any,
// is registered in r_out when that word advances.
// Throughput: one word per cycle; a full result register stalls input only
// while the downstream side stalls.
// Reset: synchronous, active low; the parser idles awaiting a start byte.
// ============================================================================
// StackMapTable decoder
// Parses a StackMapTable attribute body one byte per word into records.
// ============================================================================
`default_nettype none

module stack_map_table_decoder
    import smt_dec_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_data
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_CNT_LO   = 3'd1;
    localparam logic [2:0] PH_FRAME    = 3'd2;
    localparam logic [2:0] PH_DELTA_HI = 3'd3;
    localparam logic [2:0] PH_DELTA_LO = 3'd4;
    localparam logic [2:0] PH_TAG      = 3'd5;
    localparam logic [2:0] PH_ARG_HI   = 3'd6;
    localparam logic [2:0] PH_ARG_LO   = 3'd7;

    logic        r_in_valid;
    t_in_word    r_in;
    logic        r_out_valid;
    t_out_word   r_out;

    logic [2:0]  r_phase,   n_phase;
    logic [15:0] r_entries, n_entries;
    logic [15:0] r_bci,     n_bci;
    logic [1:0]  r_locals,  n_locals;
    logic [7:0]  r_high,    n_high;
    logic [3:0]  r_tag,     n_tag;

    logic        res_valid;
    t_out_word   res;
    logic        advance;
    logic [7:0]  b;
    logic [15:0] entries_dec;
    logic [1:0]  locals_dec;
    logic        last_entry;
    logic        last_local;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign b           = r_in.data_byte;
    assign entries_dec = r_entries - 16'd1;
    assign locals_dec  = r_locals - 2'd1;
    assign last_entry  = (entries_dec == 16'd0);
    assign last_local  = (locals_dec == 2'd0);

    always_comb begin
        n_phase   = r_phase;
        n_entries = r_entries;
        n_bci     = r_bci;
        n_locals  = r_locals;
        n_high    = r_high;
        n_tag     = r_tag;
        res_valid = 1'b0;
        res       = '0;
        if (r_in.start_req) begin
            n_high    = b;
            n_bci     = 16'hFFFF;
            n_entries = 16'd0;
            n_locals  = 2'd0;
            n_tag     = 4'd0;
            n_phase   = PH_CNT_LO;
        end else begin
            case (r_phase)
                PH_CNT_LO: begin
                    n_entries = {r_high, b};
                    if ({r_high, b} == 16'd0) begin
                        n_phase         = PH_IDLE;
                        res_valid       = 1'b1;
                        res.record_kind = KIND_EMPTY;
                        res.table_end   = 1'b1;
                    end else begin
                        n_phase = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (b <= SAME_MAX) begin
                        n_bci           = r_bci + {8'd0, b} + 16'd1;
                        n_entries       = entries_dec;
                        n_phase         = last_entry ? PH_IDLE : PH_FRAME;
                        res_valid       = 1'b1;
                        res.record_kind = KIND_SAME;
                        res.bci         = n_bci;
                        res.table_end   = last_entry;
                    end else if (b >= APPEND_MIN && b <= APPEND_MAX) begin
                        n_locals = 2'(b - APPEND_BASE);
                        n_phase  = PH_DELTA_HI;
                    end else begin
                        n_phase         = PH_IDLE;
                        res_valid       = 1'b1;
                        res.record_kind = KIND_ERROR;
                        res.error_code  = ERR_FRAME_TYPE;
                        res.table_end   = 1'b1;
                    end
                end
                PH_DELTA_HI: begin
                    n_high  = b;
                    n_phase = PH_DELTA_LO;
                end
                PH_DELTA_LO: begin
                    n_bci           = r_bci + {r_high, b} + 16'd1;
                    n_phase         = PH_TAG;
                    res_valid       = 1'b1;
                    res.record_kind = KIND_APPEND;
                    res.bci         = n_bci;
                    res.local_count = r_locals;
                end
                PH_TAG: begin
                    if (b > TAG_MAX) begin
                        n_phase         = PH_IDLE;
                        res_valid       = 1'b1;
                        res.record_kind = KIND_ERROR;
                        res.error_code  = ERR_TYPE_TAG;
                        res.table_end   = 1'b1;
                    end else if (b == TAG_CLASS || b == TAG_UNINIT) begin
                        n_tag   = tag_to_code(b[3:0]);
                        n_phase = PH_ARG_HI;
                    end else begin
                        n_locals        = locals_dec;
                        res_valid       = 1'b1;
                        res.record_kind = KIND_LOCAL;
                        res.bci         = r_bci;
                        res.type_code   = tag_to_code(b[3:0]);
                        if (last_local) begin
                            n_entries     = entries_dec;
                            n_phase       = last_entry ? PH_IDLE : PH_FRAME;
                            res.table_end = last_entry;
                        end
                    end
                end
                PH_ARG_HI: begin
                    n_high  = b;
                    n_phase = PH_ARG_LO;
                end
                PH_ARG_LO: begin
                    n_locals        = locals_dec;
                    n_phase         = PH_TAG;
                    res_valid       = 1'b1;
                    res.record_kind = KIND_LOCAL;
                    res.bci         = r_bci;
                    res.type_code   = r_tag;
                    if (r_tag == CODE_UNINIT_OFFSET) begin
                        res.type_offset = {r_high, b};
                    end
                    if (last_local) begin
                        n_entries     = entries_dec;
                        n_phase       = last_entry ? PH_IDLE : PH_FRAME;
                        res.table_end = last_entry;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_entries   <= 16'd0;
            r_bci       <= 16'hFFFF;
            r_locals    <= 2'd0;
            r_high      <= 8'd0;
            r_tag       <= 4'd0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_phase   <= n_phase;
                r_entries <= n_entries;
                r_bci     <= n_bci;
                r_locals  <= n_locals;
                r_high    <= n_high;
                r_tag     <= n_tag;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire
